// ----- rtl/core/vct_pkg.sv -----
package vct_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned WordW             = 32;
  localparam int unsigned CfgIdxW           = 2;
  localparam int unsigned ExtLeafBit        = 31;
  localparam logic [WordW-1:0] LimitedTopLeaf = 32'd2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } vct_op_e;

  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_FULL = 1'b1
  } vct_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASIC_MAX_LEAF = 2'd0,
    CFG_EXT_MAX_LEAF   = 2'd1,
    CFG_LIMIT_MODE     = 2'd2
  } vct_cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MID_CHK,
    ST_SCAN,
    ST_FIN
  } vct_st_e;

  // one request as seen by the controller
  typedef struct packed {
    vct_op_e          operation;
    logic [WordW-1:0] leaf;
    logic [WordW-1:0] subleaf;
    logic             check_subleaf;
    logic [WordW-1:0] word_a;
    logic [WordW-1:0] word_b;
    logic [WordW-1:0] word_c;
    logic [WordW-1:0] word_d;
  } vct_req_t;

  // key part of a table entry
  typedef struct packed {
    logic             chk;
    logic [WordW-1:0] subleaf;
    logic [WordW-1:0] leaf;
  } vct_key_ent_t;

  localparam int unsigned KeyEntW  = $bits(vct_key_ent_t);
  localparam int unsigned WordEntW = 4 * WordW;

  // finished request handed from controller to the output register
  typedef struct packed {
    logic             valid;
    vct_op_e          op;
    vct_status_e      status;
    logic             hit;
    logic [WordW-1:0] leaf;
  } vct_done_t;

endpackage

// ----- rtl/core/vct_req_if.sv -----
interface vct_req_if import vct_pkg::*;;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [WordW-1:0] leaf;
  logic [WordW-1:0] subleaf;
  logic             check_subleaf;
  logic [WordW-1:0] word_a;
  logic [WordW-1:0] word_b;
  logic [WordW-1:0] word_c;
  logic [WordW-1:0] word_d;

  modport source (
    output valid, operation, leaf, subleaf, check_subleaf, word_a, word_b, word_c, word_d,
    input  ready
  );
  modport sink (
    input  valid, operation, leaf, subleaf, check_subleaf, word_a, word_b, word_c, word_d,
    output ready
  );
endinterface

// ----- rtl/core/vct_rsp_if.sv -----
interface vct_rsp_if import vct_pkg::*;;
  logic             valid;
  logic             ready;
  logic             status;
  logic             hit;
  logic [WordW-1:0] out_a;
  logic [WordW-1:0] out_b;
  logic [WordW-1:0] out_c;
  logic [WordW-1:0] out_d;

  modport source (
    output valid, status, hit, out_a, out_b, out_c, out_d,
    input  ready
  );
  modport sink (
    input  valid, status, hit, out_a, out_b, out_c, out_d,
    output ready
  );
endinterface

// ----- rtl/core/vct_cfg_if.sv -----
interface vct_cfg_if import vct_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/core/vct_ram.sv -----
module vct_ram import vct_pkg::*; #(
  parameter int unsigned Depth = TableDepthDefault,
  parameter int unsigned Width = KeyEntW,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/vct_ctrl.sv -----
module vct_ctrl import vct_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  localparam int unsigned AddrW = $clog2(TableDepth),
  localparam int unsigned CntW  = $clog2(TableDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  vct_req_t         req_i,
  input  logic [WordW-1:0] basic_max_i,
  input  logic [WordW-1:0] ext_max_i,
  input  vct_key_ent_t     key_rdata_i,
  output logic             key_re_o,
  output logic [AddrW-1:0] key_raddr_o,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic             word_re_o,
  output logic [AddrW-1:0] word_raddr_o,
  output vct_done_t        done_o,
  input  logic             done_ack_i
);

  vct_st_e          state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [WordW-1:0] key_q, key_d;
  logic [WordW-1:0] sub_q, sub_d;
  logic [WordW-1:0] orig_q, orig_d;
  logic             pass_q, pass_d;
  vct_op_e          op_q, op_d;
  vct_status_e      status_q, status_d;
  logic             hit_q, hit_d;

  logic [AddrW-1:0] mid;
  logic [CntW-1:0]  nxt;
  logic [WordW-1:0] lim;
  logic             full;
  logic             leaf_lt, leaf_eq, sub_ok, can_fallback;

  assign mid  = AddrW'(cnt_q >> 1);
  assign nxt  = CntW'(pos_q) + CntW'(1);
  assign full = (cnt_q >= CntW'(TableDepth));

  assign leaf_lt = (key_rdata_i.leaf < key_q);
  assign leaf_eq = (key_rdata_i.leaf == key_q);
  assign sub_ok  = !key_rdata_i.chk || (key_rdata_i.subleaf == sub_q);

  // extended range chosen by bit 31 of the original key
  assign lim          = orig_q[ExtLeafBit] ? ext_max_i : basic_max_i;
  assign can_fallback = !pass_q && (orig_q > lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pass_q   <= 1'b0;
      hit_q    <= 1'b0;
      status_q <= STATUS_DONE;
      op_q     <= OP_INSERT;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pass_q   <= pass_d;
      hit_q    <= hit_d;
      status_q <= status_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    key_q  <= key_d;
    sub_q  <= sub_d;
    orig_q <= orig_d;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    key_d        = key_q;
    sub_d        = sub_q;
    orig_d       = orig_q;
    pass_d       = pass_q;
    op_d         = op_q;
    status_d     = status_q;
    hit_d        = hit_q;
    req_ready_o  = (state_q == ST_IDLE);
    key_re_o     = 1'b0;
    key_raddr_o  = mid;
    wr_en_o      = 1'b0;
    word_re_o    = 1'b0;
    word_raddr_o = pos_q;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.operation;
          hit_d    = 1'b0;
          status_d = STATUS_DONE;
          if (req_i.operation == OP_INSERT) begin
            if (full) begin
              status_d = STATUS_FULL;
            end else begin
              wr_en_o = 1'b1;
              cnt_d   = cnt_q + CntW'(1);
            end
            state_d = ST_FIN;
          end else begin
            key_d  = req_i.leaf;
            orig_d = req_i.leaf;
            sub_d  = req_i.subleaf;
            pass_d = 1'b0;
            if (cnt_q == '0) begin
              // empty table misses, fallback would miss too
              state_d = ST_FIN;
            end else begin
              key_re_o = 1'b1;
              state_d  = ST_MID_CHK;
            end
          end
        end
      end

      ST_MID_CHK: begin
        key_re_o = 1'b1;
        if (leaf_lt) begin
          key_raddr_o = mid;
          pos_d       = mid;
        end else begin
          key_raddr_o = '0;
          pos_d       = '0;
        end
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        if (leaf_eq && sub_ok) begin
          hit_d     = 1'b1;
          word_re_o = 1'b1;
          state_d   = ST_FIN;
        end else if ((leaf_lt || leaf_eq) && (nxt < cnt_q)) begin
          // skip entry, next read is already one ahead
          key_re_o    = 1'b1;
          key_raddr_o = AddrW'(nxt);
          pos_d       = AddrW'(nxt);
        end else if (can_fallback) begin
          pass_d   = 1'b1;
          key_d    = basic_max_i;
          key_re_o = 1'b1;
          state_d  = ST_MID_CHK;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (done_ack_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign wr_addr_o = AddrW'(cnt_q);

  assign done_o.valid  = (state_q == ST_FIN);
  assign done_o.op     = op_q;
  assign done_o.status = status_q;
  assign done_o.hit    = hit_q;
  assign done_o.leaf   = orig_q;

endmodule

// ----- rtl/core/virtual_cpuid_table_lookup_top.sv -----
// channel  | dir | payload                                         | accepted when
// ---------+-----+-------------------------------------------------+----------------------
// cfg_i    | in  | index, data                                     | valid & ready
// req_i    | in  | operation, leaf, subleaf, check_subleaf, words  | valid & ready
// rsp_o    | out | status, hit, out_a .. out_d                     | valid & ready
//
// an insert goes to its response without a scan; a lookup checks the midpoint entry, then
// scans with one key memory read per cycle, and when the fallback pass runs it does a
// second midpoint check and scan
// reset clears the entry count, the config registers and all control state; the
// tables themselves are not cleared, only entries below the count are ever read
// a finished response sits in the output register, so the next request is taken
// while the previous response is still stalled by rsp_o.ready
module virtual_cpuid_table_lookup_top import vct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vct_cfg_if.sink   cfg_i,
  vct_req_if.sink   req_i,
  vct_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  // config registers
  logic [WordW-1:0] basic_max_q;
  logic [WordW-1:0] ext_max_q;
  logic             limit_q;

  // request packed for the controller
  vct_req_t req;

  // memory ports
  logic             key_re, word_re, wr_en;
  logic [AddrW-1:0] key_raddr, word_raddr, wr_addr;
  vct_key_ent_t     key_wdata, key_rdata;
  logic [KeyEntW-1:0]  key_rdata_raw;
  logic [WordEntW-1:0] word_wdata, word_rdata;

  // output side
  vct_done_t        done;
  logic             out_load;
  logic             rsp_valid_q;
  logic             rsp_status_q, rsp_hit_q;
  logic [WordW-1:0] rsp_a_q, rsp_b_q, rsp_c_q, rsp_d_q;
  logic [WordW-1:0] res_a, res_b, res_c, res_d;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basic_max_q <= '0;
      ext_max_q   <= '0;
      limit_q     <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BASIC_MAX_LEAF: basic_max_q <= cfg_i.data;
        CFG_EXT_MAX_LEAF:   ext_max_q   <= cfg_i.data;
        CFG_LIMIT_MODE:     limit_q     <= cfg_i.data[0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  assign req.operation     = vct_op_e'(req_i.operation);
  assign req.leaf          = req_i.leaf;
  assign req.subleaf       = req_i.subleaf;
  assign req.check_subleaf = req_i.check_subleaf;
  assign req.word_a        = req_i.word_a;
  assign req.word_b        = req_i.word_b;
  assign req.word_c        = req_i.word_c;
  assign req.word_d        = req_i.word_d;

  // sequencer: owns the entry count, the scan position and the fallback pass
  vct_ctrl #(
    .TableDepth (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_i        (req),
    .basic_max_i  (basic_max_q),
    .ext_max_i    (ext_max_q),
    .key_rdata_i  (key_rdata),
    .key_re_o     (key_re),
    .key_raddr_o  (key_raddr),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .word_re_o    (word_re),
    .word_raddr_o (word_raddr),
    .done_o       (done),
    .done_ack_i   (out_load)
  );

  // inserts write straight from the request payload in the accept cycle;
  // reads and writes never overlap since one request is worked at a time
  assign key_wdata.chk     = req_i.check_subleaf;
  assign key_wdata.subleaf = req_i.subleaf;
  assign key_wdata.leaf    = req_i.leaf;
  assign word_wdata        = {req_i.word_a, req_i.word_b, req_i.word_c, req_i.word_d};

  // key memory: leaf, subleaf and check flag, read once per scan step
  vct_ram #(
    .Depth (TABLE_DEPTH),
    .Width (KeyEntW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata_raw)
  );

  assign key_rdata = vct_key_ent_t'(key_rdata_raw);

  // answer memory: four words, read once on a hit
  vct_ram #(
    .Depth (TABLE_DEPTH),
    .Width (WordEntW)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (word_wdata),
    .re_i    (word_re),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  // answer words, zero on miss, then limit mode on the original key
  always_comb begin
    if (done.hit) begin
      {res_a, res_b, res_c, res_d} = word_rdata;
    end else begin
      {res_a, res_b, res_c, res_d} = '0;
    end
    if (limit_q && (done.op == OP_LOOKUP)) begin
      if (done.leaf == '0) begin
        res_a = LimitedTopLeaf;
      end else if (done.leaf > LimitedTopLeaf) begin
        res_a = '0;
        res_b = '0;
        res_c = '0;
        res_d = '0;
      end
    end
  end

  // output register, loaded when empty or being drained
  assign out_load = done.valid && (!rsp_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_status_q <= done.status;
      rsp_hit_q    <= done.hit;
      rsp_a_q      <= res_a;
      rsp_b_q      <= res_b;
      rsp_c_q      <= res_c;
      rsp_d_q      <= res_d;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.hit    = rsp_hit_q;
  assign rsp_o.out_a  = rsp_a_q;
  assign rsp_o.out_b  = rsp_b_q;
  assign rsp_o.out_c  = rsp_c_q;
  assign rsp_o.out_d  = rsp_d_q;

  // block is not ready again in the cycle after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken right after another");

  // a refused insert never reports a hit
  a_full_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == STATUS_FULL)) |-> !rsp_o.hit)
    else $error("full status together with hit");

  // a miss without limit mode answers with zeros
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !done.hit && !limit_q) |=>
      (rsp_o.out_a == '0) && (rsp_o.out_b == '0) && (rsp_o.out_c == '0) &&
      (rsp_o.out_d == '0))
    else $error("miss with nonzero answer");

  // a finished request shows up on the response port
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> rsp_o.valid)
    else $error("response lost on load");

endmodule
